// ===== sv/rsav_pkg.sv =====
package rsav_pkg;

    localparam int COORD_BITS = 24;
    localparam int OUT_BITS   = 16;
    localparam int DIM_BITS   = 16;

    // projected extents are twice a coordinate magnitude plus a sensor size
    localparam int MAG_BITS   = COORD_BITS + 1;
    localparam int DIST_BITS  = COORD_BITS;
    localparam int SUM_BITS   = 2 * MAG_BITS + 2;
    localparam int SQRT_STEPS = SUM_BITS / 2;
    localparam int YP_BITS    = 2 * MAG_BITS;
    localparam int XP_BITS    = DIST_BITS + SQRT_STEPS + 1;

    localparam int NORM_BITS    = 30;
    localparam int SHIFT_BITS   = $clog2(XP_BITS - NORM_BITS + 1);
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = NORM_BITS + 3;
    localparam int ZW           = 32;
    localparam int ANGLE_BITS   = 30;
    localparam logic [ANGLE_BITS-1:0] ANGLE_MAX = ANGLE_BITS'(1) << 29;

    // squares, sum, root steps, cross product, three normalize, rotations, clamp
    localparam int TERM_LAT  = 2 + SQRT_STEPS + 1 + 3 + CORDIC_STEPS + 1;
    localparam int TOT_BITS  = ANGLE_BITS + 4;
    localparam int RND_SHIFT = 32 - OUT_BITS;

    // atan(2^-i) in units of pi/2^30
    localparam logic [ANGLE_BITS-1:0] ATAN_TAB [CORDIC_STEPS] = '{
        30'd268435456, 30'd158466703, 30'd83729454, 30'd42502378, 30'd21333665,
        30'd10677233,  30'd5339919,   30'd2670123,  30'd1335082,  30'd667543,
        30'd333772,    30'd166886,    30'd83443,    30'd41722,    30'd20861,
        30'd10430,     30'd5215,      30'd2608,     30'd1304,     30'd652,
        30'd326,       30'd163,       30'd81,       30'd41,       30'd20,
        30'd10,        30'd5,         30'd3,        30'd1,        30'd1
    };

    typedef enum logic [1:0] {
        AXIS_X   = 2'd0,
        AXIS_Y   = 2'd1,
        AXIS_Z   = 2'd2,
        AXIS_BAD = 2'd3
    } t_axis;

    typedef struct packed {
        logic [YP_BITS-1:0]   yp;
        logic [DIST_BITS-1:0] d;
    } t_sqrt_side;

    typedef struct packed {
        logic out_y;
        logic out_z;
        logic bad;
    } t_side;

    function automatic logic [COORD_BITS-1:0] coord_abs(input logic [COORD_BITS-1:0] v);
        logic [COORD_BITS-1:0] r;
        r = v[COORD_BITS-1] ? (~v) + COORD_BITS'(1) : v;
        return r;
    endfunction

endpackage

// ===== sv/rsav_in_if.sv =====
interface rsav_in_if;
    logic                              valid;
    logic                              ready;
    logic [rsav_pkg::COORD_BITS-1:0]   sep_x;
    logic [rsav_pkg::COORD_BITS-1:0]   sep_y;
    logic [rsav_pkg::COORD_BITS-1:0]   sep_z;
    logic [1:0]                        plane_axis;
    logic [rsav_pkg::DIM_BITS-1:0]     sensor_width;
    logic [rsav_pkg::DIM_BITS-1:0]     sensor_height;

    modport source (output valid, sep_x, sep_y, sep_z, plane_axis, sensor_width,
                    sensor_height, input ready);
    modport sink   (input valid, sep_x, sep_y, sep_z, plane_axis, sensor_width,
                    sensor_height, output ready);
endinterface

// ===== sv/rsav_out_if.sv =====
interface rsav_out_if;
    logic                          valid;
    logic                          ready;
    logic [rsav_pkg::OUT_BITS-1:0] visibility;
    logic                          bad_geometry;

    modport source (output valid, visibility, bad_geometry, input ready);
    modport sink   (input valid, visibility, bad_geometry, output ready);
endinterface

// ===== sv/rsav_isqrt.sv =====
module rsav_isqrt (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [rsav_pkg::SUM_BITS-1:0]   i_n,
    input  rsav_pkg::t_sqrt_side            i_side,
    output logic [rsav_pkg::SQRT_STEPS-1:0] o_root,
    output rsav_pkg::t_sqrt_side            o_side
);
    localparam int SB = rsav_pkg::SUM_BITS;
    localparam int NS = rsav_pkg::SQRT_STEPS;

    logic [SB-1:0]        r_n    [NS];
    logic [SB-1:0]        r_r    [NS];
    rsav_pkg::t_sqrt_side r_side [NS];

    for (genvar k = 0; k < NS; k++) begin : g_step
        logic [SB-1:0]        n_in;
        logic [SB-1:0]        r_in;
        rsav_pkg::t_sqrt_side side_in;
        logic [SB-1:0]        bitv;
        logic [SB:0]          trial;

        if (k == 0) begin : g_first
            assign n_in    = i_n;
            assign r_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign n_in    = r_n[k-1];
            assign r_in    = r_r[k-1];
            assign side_in = r_side[k-1];
        end

        assign bitv  = SB'(1) << (SB - 2 - 2 * k);
        assign trial = {1'b0, r_in} + {1'b0, bitv};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if ({1'b0, n_in} >= trial) begin
                    r_n[k] <= n_in - trial[SB-1:0];
                    r_r[k] <= (r_in >> 1) + bitv;
                end else begin
                    r_n[k] <= n_in;
                    r_r[k] <= r_in >> 1;
                end
                r_side[k] <= side_in;
            end
        end
    end

    assign o_root = r_r[NS-1][NS-1:0];
    assign o_side = r_side[NS-1];

endmodule

// ===== sv/rsav_cordic.sv =====
module rsav_cordic (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [rsav_pkg::XP_BITS-1:0]    i_x,
    input  logic [rsav_pkg::YP_BITS-1:0]    i_y,
    output logic [rsav_pkg::ANGLE_BITS-1:0] o_angle
);
    localparam int XB = rsav_pkg::XP_BITS;
    localparam int NB = rsav_pkg::NORM_BITS;
    localparam int SH = rsav_pkg::SHIFT_BITS;
    localparam int CW = rsav_pkg::CW;
    localparam int ZW = rsav_pkg::ZW;
    localparam int NI = rsav_pkg::CORDIC_STEPS;

    // normalize: OR, leading-one search, shift
    logic [XB-1:0] r_m, r_x1, r_y1;
    logic          r_yz1;
    logic [SH-1:0] r_sh2, n_sh2;
    logic [XB-1:0] r_x2, r_y2;
    logic          r_yz2;

    logic signed [CW-1:0] r_cx [NI+1];
    logic signed [CW-1:0] r_cy [NI+1];
    logic signed [ZW-1:0] r_cz [NI+1];
    logic                 r_yz [NI+1];
    logic [rsav_pkg::ANGLE_BITS-1:0] r_angle;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m   <= i_x | XB'(i_y);
            r_x1  <= i_x;
            r_y1  <= XB'(i_y);
            r_yz1 <= (i_y == '0);
        end
    end

    always_comb begin
        n_sh2 = '0;
        for (int j = NB; j < XB; j++) begin
            if (r_m[j]) n_sh2 = SH'(j - NB + 1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sh2 <= n_sh2;
            r_x2  <= r_x1;
            r_y2  <= r_y1;
            r_yz2 <= r_yz1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cx[0] <= $signed(CW'(r_x2 >> r_sh2));
            r_cy[0] <= $signed(CW'(r_y2 >> r_sh2));
            r_cz[0] <= '0;
            r_yz[0] <= r_yz2;
        end
    end

    for (genvar i = 0; i < NI; i++) begin : g_rot
        logic signed [CW-1:0] dx, dy;
        logic signed [ZW-1:0] da;

        assign dx = r_cy[i] >>> i;
        assign dy = r_cx[i] >>> i;
        assign da = $signed(ZW'(rsav_pkg::ATAN_TAB[i]));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!r_cy[i][CW-1]) begin
                    r_cx[i+1] <= r_cx[i] + dx;
                    r_cy[i+1] <= r_cy[i] - dy;
                    r_cz[i+1] <= r_cz[i] + da;
                end else begin
                    r_cx[i+1] <= r_cx[i] - dx;
                    r_cy[i+1] <= r_cy[i] + dy;
                    r_cz[i+1] <= r_cz[i] - da;
                end
                r_yz[i+1] <= r_yz[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_yz[NI] || r_cz[NI] < 0)
                r_angle <= '0;
            else if (r_cz[NI] > $signed(ZW'(rsav_pkg::ANGLE_MAX)))
                r_angle <= rsav_pkg::ANGLE_MAX;
            else
                r_angle <= rsav_pkg::ANGLE_BITS'(r_cz[NI]);
        end
    end

    assign o_angle = r_angle;

endmodule

// ===== sv/rsav_term.sv =====
module rsav_term (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  logic [rsav_pkg::MAG_BITS-1:0]   i_p,
    input  logic [rsav_pkg::MAG_BITS-1:0]   i_q,
    input  logic [rsav_pkg::DIST_BITS-1:0]  i_d,
    output logic [rsav_pkg::ANGLE_BITS-1:0] o_angle
);
    localparam int YB = rsav_pkg::YP_BITS;
    localparam int DB = rsav_pkg::DIST_BITS;
    localparam int SB = rsav_pkg::SUM_BITS;
    localparam int XB = rsav_pkg::XP_BITS;

    logic [YB-1:0]   r_pp, r_qq, r_yp1;
    logic [2*DB-1:0] r_dd;
    logic [DB-1:0]   r_d1;
    logic [SB-1:0]   r_sum;
    rsav_pkg::t_sqrt_side r_side2, sq_side;
    logic [rsav_pkg::SQRT_STEPS-1:0] sq_root;
    logic [XB-1:0]   r_xp;
    logic [YB-1:0]   r_yp3;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp  <= YB'(i_p) * YB'(i_p);
            r_qq  <= YB'(i_q) * YB'(i_q);
            r_yp1 <= YB'(i_p) * YB'(i_q);
            r_dd  <= (2*DB)'(i_d) * (2*DB)'(i_d);
            r_d1  <= i_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum      <= SB'(r_pp) + SB'(r_qq) + SB'({r_dd, 2'b00});
            r_side2.yp <= r_yp1;
            r_side2.d  <= r_d1;
        end
    end

    rsav_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_n    (r_sum),
        .i_side (r_side2),
        .o_root (sq_root),
        .o_side (sq_side)
    );

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xp  <= XB'({(XB-1)'(sq_side.d) * (XB-1)'(sq_root), 1'b0});
            r_yp3 <= sq_side.yp;
        end
    end

    rsav_cordic u_cordic (
        .i_clk   (i_clk),
        .i_en    (i_en),
        .i_x     (r_xp),
        .i_y     (r_yp3),
        .o_angle (o_angle)
    );

endmodule

// ===== sv/rectangle_solid_angle_visibility_top.sv =====
// Solid angle of a rectangular sensor seen from a point, as a fraction of 4*pi.
// Input channel i_in: one word per point/sensor pair (separation vector in
// signed Q16.8 cm, normal axis code, width and height in Q8.8 cm).
// Output channel o_out: one word per input word, in order: visibility in
// Q0.16 and a flag for a point in the sensor plane or an invalid axis code.
// Each word passes four corner-angle lanes, each with square and sum stages, a
// 26-stage square root, a cross product, a 3-stage normalizer and a
// 30-stage CORDIC, between an input register and the sum and output registers.
// Throughput is one word per cycle unless stalled; the rotation stages of the
// CORDIC and the square root steps set the depth.
// Reset clears all valid bits; the pipeline comes up empty and ready.
// When the receiver holds o_out.ready low with a word waiting, the whole
// pipeline freezes and i_in.ready drops; nothing is lost or repeated.
// Bubbles inside the pipeline are kept while stalled.
module rectangle_solid_angle_visibility_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rsav_in_if.sink    i_in,
    rsav_out_if.source o_out
);
    localparam int CB = rsav_pkg::COORD_BITS;
    localparam int MB = rsav_pkg::MAG_BITS;
    localparam int AB = rsav_pkg::ANGLE_BITS;
    localparam int TB = rsav_pkg::TOT_BITS;
    localparam int OB = rsav_pkg::OUT_BITS;
    localparam int LAT = rsav_pkg::TERM_LAT;

    logic en;

    logic [CB-1:0] ax, ay, az, pd, pu, pv;
    logic [MB-1:0] u2, v2, w, h;
    logic          oy, oz;

    logic [MB-1:0] r_sp_y, r_dm_y, r_sp_z, r_dm_z;
    logic [CB-1:0] r_d;
    logic          r_vld0;
    rsav_pkg::t_side r_side0;

    logic          r_dl_vld  [LAT];
    rsav_pkg::t_side r_dl_side [LAT];

    logic [AB-1:0] t1, t2, t3, t4;

    logic signed [TB-1:0] r_tot, n_tot;
    logic          r_sum_vld, r_sum_bad;

    logic [TB-1:0] rnd;
    logic [OB-1:0] n_vis, r_vis;
    logic          r_out_vld, r_out_bad;

    assign en         = !r_out_vld || o_out.ready;
    assign i_in.ready = en;

    // projection so that the plane normal comes first
    always_comb begin
        ax = rsav_pkg::coord_abs(i_in.sep_x);
        ay = rsav_pkg::coord_abs(i_in.sep_y);
        az = rsav_pkg::coord_abs(i_in.sep_z);
        unique case (rsav_pkg::t_axis'(i_in.plane_axis))
            rsav_pkg::AXIS_X: begin pd = ax; pu = ay; pv = az; end
            rsav_pkg::AXIS_Y: begin pd = ay; pu = ax; pv = az; end
            default:          begin pd = az; pu = ay; pv = ax; end
        endcase
        u2 = {pu, 1'b0};
        v2 = {pv, 1'b0};
        w  = MB'(i_in.sensor_width);
        h  = MB'(i_in.sensor_height);
        oy = u2 > w;
        oz = v2 > h;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld0 <= 1'b0;
        end else if (en) begin
            r_vld0 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sp_y        <= u2 + w;
            r_dm_y        <= oy ? u2 - w : w - u2;
            r_sp_z        <= v2 + h;
            r_dm_z        <= oz ? v2 - h : h - v2;
            r_d           <= pd;
            r_side0.out_y <= oy;
            r_side0.out_z <= oz;
            r_side0.bad   <= (i_in.plane_axis == rsav_pkg::AXIS_BAD) || (pd == '0);
        end
    end

    rsav_term u_term_pp (.i_clk(i_clk), .i_en(en), .i_p(r_sp_y), .i_q(r_sp_z),
                         .i_d(r_d), .o_angle(t1));
    rsav_term u_term_mp (.i_clk(i_clk), .i_en(en), .i_p(r_dm_y), .i_q(r_sp_z),
                         .i_d(r_d), .o_angle(t2));
    rsav_term u_term_pm (.i_clk(i_clk), .i_en(en), .i_p(r_sp_y), .i_q(r_dm_z),
                         .i_d(r_d), .o_angle(t3));
    rsav_term u_term_mm (.i_clk(i_clk), .i_en(en), .i_p(r_dm_y), .i_q(r_dm_z),
                         .i_d(r_d), .o_angle(t4));

    // valid and quadrant flags ride alongside the corner lanes
    for (genvar j = 0; j < LAT; j++) begin : g_dl
        logic            vin;
        rsav_pkg::t_side sin;
        if (j == 0) begin : g_first
            assign vin = r_vld0;
            assign sin = r_side0;
        end else begin : g_next
            assign vin = r_dl_vld[j-1];
            assign sin = r_dl_side[j-1];
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dl_vld[j] <= 1'b0;
            end else if (en) begin
                r_dl_vld[j] <= vin;
            end
        end
        always_ff @(posedge i_clk) begin
            if (en) r_dl_side[j] <= sin;
        end
    end

    always_comb begin
        rsav_pkg::t_side s;
        s = r_dl_side[LAT-1];
        n_tot = $signed(TB'(t1));
        n_tot = s.out_y ? n_tot - $signed(TB'(t2)) : n_tot + $signed(TB'(t2));
        n_tot = s.out_z ? n_tot - $signed(TB'(t3)) : n_tot + $signed(TB'(t3));
        n_tot = (s.out_y != s.out_z) ? n_tot - $signed(TB'(t4))
                                     : n_tot + $signed(TB'(t4));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_vld <= 1'b0;
        end else if (en) begin
            r_sum_vld <= r_dl_vld[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_tot     <= n_tot;
            r_sum_bad <= r_dl_side[LAT-1].bad;
        end
    end

    // round half up, zero for a flagged word, clamp below at zero, saturate above
    always_comb begin
        rnd = (TB'(r_tot) + (TB'(1) << (rsav_pkg::RND_SHIFT - 1))) >> rsav_pkg::RND_SHIFT;
        if (r_sum_bad || r_tot < 0)
            n_vis = '0;
        else if (rnd > TB'({OB{1'b1}}))
            n_vis = '1;
        else
            n_vis = OB'(rnd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_sum_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vis     <= n_vis;
            r_out_bad <= r_sum_bad;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.visibility   = r_vis;
    assign o_out.bad_geometry = r_out_bad;

`ifndef SYNTHESIS
    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out_bad |-> r_vis == '0)
        else $error("flagged word carries nonzero visibility");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sum_vld && !en |=> $stable(r_tot) && r_sum_vld)
        else $error("sum stage changed during stall");

    a_term_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dl_vld[LAT-1] |-> t1 <= rsav_pkg::ANGLE_MAX && t2 <= rsav_pkg::ANGLE_MAX
                            && t3 <= rsav_pkg::ANGLE_MAX && t4 <= rsav_pkg::ANGLE_MAX)
        else $error("corner angle out of range");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_vld |-> i_in.ready)
        else $error("input stalled with empty output");
`endif

endmodule

// ===== sim/rsav_checker.sv =====
`timescale 1ns / 100ps

module rsav_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rsav_in_if    i_in,
    rsav_out_if   o_out,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_results
);
    typedef struct {
        logic [rsav_pkg::OUT_BITS-1:0] visibility;
        logic                          bad_geometry;
    } t_vis_result;

    localparam int ATAN_UNITS [30] = '{
        268435456, 158466703, 83729454, 42502378, 21333665, 10677233, 5339919,
        2670123, 1335082, 667543, 333772, 166886, 83443, 41722, 20861, 10430,
        5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1
    };

    t_vis_result vis_queue[$];
    int          mismatches;

    // flooring arithmetic shift
    function automatic longint floor_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint int_root(longint unsigned n);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= r + bitv) begin
                n -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint vector_angle(longint unsigned yv, longint unsigned xv);
        longint x, y, z, dx, dy;
        z = 0;
        if (yv == 0) return 0;
        while (yv >= (64'd1 << 30) || xv >= (64'd1 << 30)) begin
            yv >>= 1;
            xv >>= 1;
        end
        x = longint'(xv);
        y = longint'(yv);
        for (int i = 0; i < 30; i++) begin
            dx = floor_shr(y, i);
            dy = floor_shr(x, i);
            if (y >= 0) begin
                x += dx; y -= dy; z += ATAN_UNITS[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_UNITS[i];
            end
        end
        if (z < 0) z = 0;
        if (z > (64'sd1 << 29)) z = 64'sd1 << 29;
        return z;
    endfunction

    function automatic longint quarter_angle(longint unsigned p, longint unsigned q,
                                             longint unsigned d);
        longint unsigned root;
        while ((p | q | d) >= (64'd1 << 25)) begin
            p >>= 1; q >>= 1; d >>= 1;
        end
        root = int_root(p * p + q * q + 4 * d * d);
        return vector_angle(p * q, 2 * d * root);
    endfunction

    function automatic longint unsigned mag(logic [rsav_pkg::COORD_BITS-1:0] v);
        return v[rsav_pkg::COORD_BITS-1]
            ? longint'((~v) + 1'b1) & ((64'd1 << rsav_pkg::COORD_BITS) - 1)
            : longint'(v);
    endfunction

    function automatic t_vis_result predict_visibility(
        logic [rsav_pkg::COORD_BITS-1:0] sx, logic [rsav_pkg::COORD_BITS-1:0] sy,
        logic [rsav_pkg::COORD_BITS-1:0] sz, rsav_pkg::t_axis axis,
        logic [rsav_pkg::DIM_BITS-1:0] wd, logic [rsav_pkg::DIM_BITS-1:0] ht);
        t_vis_result res;
        longint unsigned d, u2, v2, w, h, sp_y, dm_y, sp_z, dm_z, r;
        longint total, t2, t3, t4;
        logic out_y, out_z;
        w = wd;
        h = ht;
        case (axis)
            rsav_pkg::AXIS_X: begin d = mag(sx); u2 = mag(sy); v2 = mag(sz); end
            rsav_pkg::AXIS_Y: begin d = mag(sy); u2 = mag(sx); v2 = mag(sz); end
            default: begin d = mag(sz); u2 = mag(sy); v2 = mag(sx); end
        endcase
        if (axis == rsav_pkg::AXIS_BAD || d == 0) begin
            res.visibility = '0;
            res.bad_geometry = 1'b1;
            return res;
        end
        u2 *= 2;
        v2 *= 2;
        out_y = u2 > w;
        out_z = v2 > h;
        sp_y = u2 + w;
        dm_y = out_y ? u2 - w : w - u2;
        sp_z = v2 + h;
        dm_z = out_z ? v2 - h : h - v2;
        total = quarter_angle(sp_y, sp_z, d);
        t2 = quarter_angle(dm_y, sp_z, d);
        t3 = quarter_angle(sp_y, dm_z, d);
        t4 = quarter_angle(dm_y, dm_z, d);
        total += out_y ? -t2 : t2;
        total += out_z ? -t3 : t3;
        total += (out_y != out_z) ? -t4 : t4;
        if (total < 0) total = 0;
        r = (longint'(total) + (64'd1 << (rsav_pkg::RND_SHIFT - 1))) >> rsav_pkg::RND_SHIFT;
        if (r > (64'd1 << rsav_pkg::OUT_BITS) - 1) r = (64'd1 << rsav_pkg::OUT_BITS) - 1;
        res.visibility = r[rsav_pkg::OUT_BITS-1:0];
        res.bad_geometry = 1'b0;
        return res;
    endfunction

    assign o_fail_count = mismatches;

    initial begin
        mismatches = 0;
        o_results = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_vis_result want;
        if (i_rst_n && i_in.valid && i_in.ready) begin
            vis_queue.push_back(predict_visibility(i_in.sep_x, i_in.sep_y, i_in.sep_z,
                rsav_pkg::t_axis'(i_in.plane_axis), i_in.sensor_width,
                i_in.sensor_height));
        end
        if (i_rst_n && o_out.valid && o_out.ready) begin
            o_results <= o_results + 1;
            if (vis_queue.size() == 0) begin
                mismatches <= mismatches + 1;
                if (mismatches < 10)
                    $display("unexpected word: vis=%0d bad=%0d", o_out.visibility,
                             o_out.bad_geometry);
            end else begin
                want = vis_queue.pop_front();
                if (want.visibility !== o_out.visibility ||
                    want.bad_geometry !== o_out.bad_geometry) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("mismatch: exp vis=%0d bad=%0d, got vis=%0d bad=%0d",
                                 want.visibility, want.bad_geometry,
                                 o_out.visibility, o_out.bad_geometry);
                end
            end
        end
        o_pending = vis_queue.size();
    end
endmodule

// ===== sim/tb_rectangle_solid_angle_visibility_top.sv =====
`timescale 1ns / 100ps

module tb_rectangle_solid_angle_visibility_top;
    localparam int RANDOM_WORDS = 1250;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int CB = rsav_pkg::COORD_BITS;
    localparam int DB = rsav_pkg::DIM_BITS;

    logic i_clk;
    logic i_rst_n;
    int   fail_count, pending, results, cycles, words_sent;

    rsav_in_if  in_ch ();
    rsav_out_if out_ch ();

    rectangle_solid_angle_visibility_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    rsav_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .o_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_results    (results)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int gap_len();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // sink side stalls, with quiet stretches
    initial begin
        out_ch.ready = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            int g;
            if ($urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b1;
                repeat ($urandom_range(50, 200)) @(posedge i_clk);
            end
            g = gap_len();
            if (g > 0) begin
                out_ch.ready <= 1'b0;
                repeat (g) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    task automatic send_word(logic [CB-1:0] sx, logic [CB-1:0] sy,
                             logic [CB-1:0] sz, rsav_pkg::t_axis ax,
                             logic [DB-1:0] wd, logic [DB-1:0] ht);
        int g;
        in_ch.valid         <= 1'b1;
        in_ch.sep_x         <= sx;
        in_ch.sep_y         <= sy;
        in_ch.sep_z         <= sz;
        in_ch.plane_axis    <= ax;
        in_ch.sensor_width  <= wd;
        in_ch.sensor_height <= ht;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        words_sent++;
        g = gap_len();
        if (g > 0) begin
            in_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // stop sending and wait until every accepted word has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [CB-1:0] rand_coord();
        case ($urandom_range(0, 4))
            0: return CB'($urandom);
            1: return CB'($signed($urandom_range(0, 4000)) - 2000);
            2: return CB'($signed($urandom_range(0, 200000)) - 100000);
            3: return {CB{$urandom_range(0, 1) == 1}};
            default: return CB'($signed($urandom_range(0, 40000)) - 20000);
        endcase
    endfunction

    function automatic logic [DB-1:0] rand_dim();
        case ($urandom_range(0, 3))
            0: return DB'($urandom);
            1: return DB'($urandom_range(0, 2000));
            2: return DB'($urandom_range(0, 16));
            default: return DB'($urandom_range(0, 20000));
        endcase
    endfunction

    initial begin
        logic [CB-1:0] cmax, cmin;
        rsav_pkg::t_axis ax;
        cmax = {1'b0, {(CB-1){1'b1}}};
        cmin = {1'b1, {(CB-1){1'b0}}};
        words_sent = 0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.sep_x = '0;
        in_ch.sep_y = '0;
        in_ch.sep_z = '0;
        in_ch.plane_axis = rsav_pkg::AXIS_X;
        in_ch.sensor_width = '0;
        in_ch.sensor_height = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // on-axis, each axis, bad axis, in-plane point, zero size, extremes
        send_word(24'd256, 24'd0, 24'd0, rsav_pkg::AXIS_X, 16'd512, 16'd512);
        send_word(24'd0, 24'd256, 24'd0, rsav_pkg::AXIS_Y, 16'd512, 16'd512);
        send_word(24'd0, 24'd0, 24'd256, rsav_pkg::AXIS_Z, 16'd512, 16'd512);
        send_word(24'd256, 24'd256, 24'd256, rsav_pkg::AXIS_BAD, 16'd512, 16'd512);
        send_word(24'd0, 24'd100, 24'd100, rsav_pkg::AXIS_X, 16'd512, 16'd512);
        send_word(24'd256, 24'd10, 24'd10, rsav_pkg::AXIS_X, 16'd0, 16'd0);
        send_word(24'd256, 24'd0, 24'd0, rsav_pkg::AXIS_X, 16'd0, 16'hffff);
        send_word(24'd1, 24'd0, 24'd0, rsav_pkg::AXIS_X, 16'hffff, 16'hffff);
        send_word(cmin, cmin, cmin, rsav_pkg::AXIS_Z, 16'hffff, 16'hffff);
        send_word(cmax, cmax, cmax, rsav_pkg::AXIS_Y, 16'hffff, 16'hffff);
        send_word(cmin, cmax, 24'hffffff, rsav_pkg::AXIS_X, 16'd1, 16'd1);
        send_word(24'hffffff, 24'd0, 24'd0, rsav_pkg::AXIS_X, 16'hffff, 16'hffff);
        send_word(24'd256, 24'd300, 24'd0, rsav_pkg::AXIS_X, 16'd512, 16'd512);
        send_word(24'd256, 24'd0, 24'hfffed4, rsav_pkg::AXIS_X, 16'd512, 16'd512);
        send_word(24'd256, 24'd300, 24'd300, rsav_pkg::AXIS_X, 16'd512, 16'd512);
        send_word(24'd256, 24'd256, 24'd256, rsav_pkg::AXIS_X, 16'd512, 16'd512);
        send_word(24'd8, 24'd2, 24'd3, rsav_pkg::AXIS_Y, 16'd4, 16'd6);

        // hold off until drained
        drain();

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            ax = rsav_pkg::t_axis'($urandom_range(0, 9) == 0 ? rsav_pkg::AXIS_BAD
                                                             : $urandom_range(0, 2));
            send_word(rand_coord(), rand_coord(), rand_coord(), ax, rand_dim(), rand_dim());
            if (n == RANDOM_WORDS / 2) begin
                drain();
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        $display("covered %0d words (axes x/y/z, bad axis, in-plane, zero and full size),",
                 words_sent);
        $display("%0d results checked under random gaps and stalls", results);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
